// ----- rtl/polar_gaussian_generator_unit_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef POLAR_GAUSSIAN_GENERATOR_UNIT_MACROS_SVH
`define POLAR_GAUSSIAN_GENERATOR_UNIT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define PGG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked through reset.
`define PGG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pgg_pkg.sv -----
package pgg_pkg;

  localparam int UNIFORM_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT  = 4;
  localparam int CFG_INDEX_W          = 8;
  localparam int CFG_DATA_W           = 16;
  localparam int SAMPLE_W             = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_MEAN_OFFSET = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STD_SCALE   = 8'd1;

  localparam logic [CFG_DATA_W-1:0] MEAN_OFFSET_RESET = 16'd0;
  localparam logic [CFG_DATA_W-1:0] STD_SCALE_RESET   = 16'd256;

  // round(2 ln 2 * 2^30)
  localparam logic [30:0] LN2X2 = 31'd1488522236;

  localparam logic signed [32:0] SAMPLE_MAX = 33'sd8388607;
  localparam logic signed [32:0] SAMPLE_MIN = -33'sd8388608;

  // Both coordinates as sign and Q1.31 magnitude.
  typedef struct packed {
    logic        neg1;
    logic [31:0] mag1;
    logic        neg2;
    logic [31:0] mag2;
  } pair_t;

  // Front end result: dividend and normalised divisor for the scale factor.
  typedef struct packed {
    logic        valid;
    pair_t       pair;
    logic [4:0]  h;
    logic [30:0] m;
    logic [53:0] num;
  } front_t;

  // One accepted pair ready for sample generation.
  typedef struct packed {
    pair_t       pair;
    logic [4:0]  h;
    logic [23:0] g;
  } item_t;

endpackage

// ----- rtl/polar_gaussian_generator_unit.sv -----
// Marsaglia polar Gaussian generator.
// Input stream: each transfer carries a pair of uniform samples. Pairs whose
// point lies outside the unit circle (or at its centre) are dropped silently.
// Output stream: two Q16.8 samples per kept pair, the second with tlast high.
// Configuration channel: index 0 writes the mean (signed Q8.8), index 1 the
// standard deviation (unsigned Q8.8); cfg_ready is always high. Write only
// while no pair is in flight.
// Pipeline: 102 register stages, of which 98 are front stages (squaring,
// normaliser, 16 log2 squarings, one bit per stage for a 48-bit divide and
// a 24-bit square root), then the queue entry and three output stages.
// Throughput: one input pair per cycle while the queue has room; the output
// side moves one sample per cycle while the receiver is ready, two samples
// per kept pair. On a receiver stall the output stages hold, the queue fills
// and the front freezes with s_axis_tready low while a finished item waits.
// Reset clears all valid flags, the queue and the registers (mean 0, sd 1.0).
module polar_gaussian_generator_unit import pgg_pkg::*; #(
  parameter int UNIFORM_BITS = UNIFORM_BITS_DEFAULT,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // uniform_a, uniform_b
  input  logic [((2*UNIFORM_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // sample
  output logic [SAMPLE_W-1:0]              m_axis_tdata,
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_INDEX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]            cfg_data
);

  logic [CFG_DATA_W-1:0] mean_offset, std_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_offset <= MEAN_OFFSET_RESET;
      std_scale   <= STD_SCALE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MEAN_OFFSET: mean_offset <= cfg_data;
        REG_STD_SCALE:   std_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  front_t front_out;
  logic   ds_valid, q_full, q_head_valid, q_pop, adv;
  item_t  ds_item, q_head;

  // freeze the front only when a finished item cannot enter the queue
  assign adv           = !q_full || !ds_valid;
  assign s_axis_tready = adv;

  pgg_front #(.UNIFORM_BITS(UNIFORM_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_axis_tvalid),
    .uniform_a (s_axis_tdata[UNIFORM_BITS-1:0]),
    .uniform_b (s_axis_tdata[2*UNIFORM_BITS-1:UNIFORM_BITS]),
    .out       (front_out)
  );

  pgg_divsqrt u_divsqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .fin       (front_out),
    .out_valid (ds_valid),
    .out_item  (ds_item)
  );

  pgg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (adv && ds_valid),
    .push_item  (ds_item),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_item  (q_head)
  );

  pgg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_head_valid),
    .head_item   (q_head),
    .mean_offset (mean_offset),
    .std_scale   (std_scale),
    .out_ready   (m_axis_tready),
    .pop         (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_sample  (m_axis_tdata),
    .out_last    (m_axis_tlast)
  );

endmodule

// ----- rtl/pgg_front.sv -----
module pgg_front import pgg_pkg::*; #(
  parameter int UNIFORM_BITS = UNIFORM_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic [UNIFORM_BITS-1:0] uniform_a,
  input  logic [UNIFORM_BITS-1:0] uniform_b,
  output front_t                  out
);

  localparam logic [UNIFORM_BITS-1:0] HALF = {1'b1, {(UNIFORM_BITS-1){1'b0}}};

  function automatic logic [32:0] map_u(input logic [UNIFORM_BITS-1:0] u);
    logic [UNIFORM_BITS-1:0] mag;
    if (u[UNIFORM_BITS-1]) begin
      mag = u & ~HALF;
    end else begin
      mag = HALF - u;
    end
    return {~u[UNIFORM_BITS-1], 32'(mag) << (32 - UNIFORM_BITS)};
  endfunction

  logic [32:0] map_a, map_b;
  assign map_a = map_u(uniform_a);
  assign map_b = map_u(uniform_b);

  logic        s0_valid;
  pair_t       s0_pair;
  logic        s1_valid;
  pair_t       s1_pair;
  logic [63:0] s1_sq1, s1_sq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
      s1_valid <= s0_valid;
    end
    if (adv) begin
      s0_pair <= '{neg1: map_a[32], mag1: map_a[31:0], neg2: map_b[32], mag2: map_b[31:0]};
      s1_pair <= s0_pair;
      s1_sq1  <= 64'(s0_pair.mag1) * 64'(s0_pair.mag1);
      s1_sq2  <= 64'(s0_pair.mag2) * 64'(s0_pair.mag2);
    end
  end

  // Normaliser: six shift stages bring the top set bit of s to bit 61.
  logic [63:0] s_sum;
  logic        s_reject;
  assign s_sum    = s1_sq1 + s1_sq2;
  assign s_reject = (s_sum == 64'd0) || (s_sum[63:62] != 2'b00);

  logic        nm_valid [7];
  pair_t       nm_pair  [7];
  logic [61:0] nm_t     [7];
  logic [5:0]  nm_lz    [7];

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid[0] <= 1'b0;
    end else if (adv) begin
      nm_valid[0] <= s1_valid && !s_reject;
    end
    if (adv) begin
      nm_pair[0] <= s1_pair;
      nm_t[0]    <= s_sum[61:0];
      nm_lz[0]   <= 6'd0;
    end
  end

  for (genvar i = 0; i < 6; i++) begin : g_norm
    localparam int SH = 32 >> i;
    logic zero_top;
    assign zero_top = (nm_t[i][61 -: SH] == '0);
    always_ff @(posedge clk) begin
      if (rst) begin
        nm_valid[i+1] <= 1'b0;
      end else if (adv) begin
        nm_valid[i+1] <= nm_valid[i];
      end
      if (adv) begin
        nm_pair[i+1] <= nm_pair[i];
        nm_t[i+1]    <= zero_top ? (nm_t[i] << SH) : nm_t[i];
        nm_lz[i+1]   <= zero_top ? (nm_lz[i] + 6'(SH)) : nm_lz[i];
      end
    end
  end

  // log2 fraction by repeated squaring, one bit per stage.
  logic        lg_valid [16];
  pair_t       lg_pair  [16];
  logic [5:0]  lg_k     [16];
  logic [30:0] lg_m0    [16];
  logic [30:0] lg_m     [16];
  logic [15:0] lg_frac  [16];

  for (genvar i = 0; i < 16; i++) begin : g_log
    logic        v_in;
    pair_t       p_in;
    logic [5:0]  k_in;
    logic [30:0] m0_in, m_in;
    logic [15:0] f_in;
    logic [61:0] prod;
    logic [31:0] mm;
    if (i == 0) begin : g_first
      assign v_in  = nm_valid[6];
      assign p_in  = nm_pair[6];
      assign k_in  = nm_lz[6] + 6'd1;
      assign m0_in = nm_t[6][61:31];
      assign m_in  = nm_t[6][61:31];
      assign f_in  = 16'd0;
    end else begin : g_next
      assign v_in  = lg_valid[i-1];
      assign p_in  = lg_pair[i-1];
      assign k_in  = lg_k[i-1];
      assign m0_in = lg_m0[i-1];
      assign m_in  = lg_m[i-1];
      assign f_in  = lg_frac[i-1];
    end
    assign prod = 62'(m_in) * 62'(m_in);
    assign mm   = prod[61:30];
    always_ff @(posedge clk) begin
      if (rst) begin
        lg_valid[i] <= 1'b0;
      end else if (adv) begin
        lg_valid[i] <= v_in;
      end
      if (adv) begin
        lg_pair[i] <= p_in;
        lg_k[i]    <= k_in;
        lg_m0[i]   <= m0_in;
        lg_m[i]    <= mm[31] ? mm[31:1] : mm[30:0];
        lg_frac[i] <= {f_in[14:0], mm[31]};
      end
    end
  end

  // Dividend: 2 ln 2 * (-log2 s), doubled for an odd shift count.
  logic [21:0] lval;
  logic [52:0] lprod;
  assign lval  = {lg_k[15], 16'd0} - {6'd0, lg_frac[15]};
  assign lprod = 53'(LN2X2) * 53'(lval);

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (adv) begin
      out.valid <= lg_valid[15];
    end
    if (adv) begin
      out.pair <= lg_pair[15];
      out.h    <= lg_k[15][5:1];
      out.m    <= lg_m0[15];
      out.num  <= lg_k[15][0] ? {lprod, 1'b0} : {1'b0, lprod};
    end
  end

endmodule

// ----- rtl/pgg_divsqrt.sv -----
module pgg_divsqrt import pgg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  front_t fin,
  output logic   out_valid,
  output item_t  out_item
);

  // Restoring division of num * 2^24 by m, one quotient bit per stage.
  logic        dv_valid [48];
  pair_t       dv_pair  [48];
  logic [4:0]  dv_h     [48];
  logic [30:0] dv_m     [48];
  logic [30:0] dv_r     [48];
  logic [47:0] dv_w     [48];

  for (genvar i = 0; i < 48; i++) begin : g_div
    logic        v_in;
    pair_t       p_in;
    logic [4:0]  h_in;
    logic [30:0] m_in, r_in;
    logic [47:0] w_in;
    logic [31:0] r2;
    logic        ge;
    if (i == 0) begin : g_first
      assign v_in = fin.valid;
      assign p_in = fin.pair;
      assign h_in = fin.h;
      assign m_in = fin.m;
      assign r_in = {1'b0, fin.num[53:24]};
      assign w_in = {fin.num[23:0], 24'd0};
    end else begin : g_next
      assign v_in = dv_valid[i-1];
      assign p_in = dv_pair[i-1];
      assign h_in = dv_h[i-1];
      assign m_in = dv_m[i-1];
      assign r_in = dv_r[i-1];
      assign w_in = dv_w[i-1];
    end
    assign r2 = {r_in, w_in[47]};
    assign ge = (r2 >= {1'b0, m_in});
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[i] <= 1'b0;
      end else if (adv) begin
        dv_valid[i] <= v_in;
      end
      if (adv) begin
        dv_pair[i] <= p_in;
        dv_h[i]    <= h_in;
        dv_m[i]    <= m_in;
        dv_r[i]    <= ge ? 31'(r2 - {1'b0, m_in}) : r2[30:0];
        dv_w[i]    <= {w_in[46:0], ge};
      end
    end
  end

  // Integer square root of the quotient, one root bit per stage.
  logic        sq_valid [24];
  pair_t       sq_pair  [24];
  logic [4:0]  sq_h     [24];
  logic [47:0] sq_x     [24];
  logic [25:0] sq_rem   [24];
  logic [23:0] sq_y     [24];

  for (genvar i = 0; i < 24; i++) begin : g_sqrt
    logic        v_in;
    pair_t       p_in;
    logic [4:0]  h_in;
    logic [47:0] x_in;
    logic [25:0] rem_in;
    logic [23:0] y_in;
    logic [27:0] r2, trial;
    logic        ge;
    if (i == 0) begin : g_first
      assign v_in   = dv_valid[47];
      assign p_in   = dv_pair[47];
      assign h_in   = dv_h[47];
      assign x_in   = dv_w[47];
      assign rem_in = 26'd0;
      assign y_in   = 24'd0;
    end else begin : g_next
      assign v_in   = sq_valid[i-1];
      assign p_in   = sq_pair[i-1];
      assign h_in   = sq_h[i-1];
      assign x_in   = sq_x[i-1];
      assign rem_in = sq_rem[i-1];
      assign y_in   = sq_y[i-1];
    end
    assign r2    = {rem_in, x_in[47:46]};
    assign trial = {2'b00, y_in, 2'b01};
    assign ge    = (r2 >= trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[i] <= 1'b0;
      end else if (adv) begin
        sq_valid[i] <= v_in;
      end
      if (adv) begin
        sq_pair[i] <= p_in;
        sq_h[i]    <= h_in;
        sq_x[i]    <= {x_in[45:0], 2'b00};
        sq_rem[i]  <= ge ? 26'(r2 - trial) : r2[25:0];
        sq_y[i]    <= {y_in[22:0], ge};
      end
    end
  end

  assign out_valid     = sq_valid[23];
  assign out_item.pair = sq_pair[23];
  assign out_item.h    = sq_h[23];
  assign out_item.g    = sq_y[23];

endmodule

// ----- rtl/pgg_queue.sv -----
module pgg_queue import pgg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/pgg_back.sv -----
module pgg_back import pgg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  item_t                 head_item,
  input  logic [CFG_DATA_W-1:0] mean_offset,
  input  logic [CFG_DATA_W-1:0] std_scale,
  input  logic                  out_ready,
  output logic                  pop,
  output logic                  out_valid,
  output logic [SAMPLE_W-1:0]   out_sample,
  output logic                  out_last
);

  logic b_adv, issue, sel;
  assign b_adv = !out_valid || out_ready;
  assign issue = b_adv && head_valid;
  // sel high: second coordinate goes out now, then the item leaves the queue
  assign pop   = issue && sel;

  logic        x_valid, x_neg, x_last;
  logic [55:0] x_prod;
  logic [4:0]  x_h;
  logic        y_valid, y_neg, y_last;
  logic [44:0] y_p;

  logic [31:0] mag_sel;
  assign mag_sel = sel ? head_item.pair.mag2 : head_item.pair.mag1;

  logic [63:0] zsh;
  logic [28:0] zmag;
  assign zsh  = 64'(x_prod) << x_h;
  assign zmag = zsh[63:35];

  logic [45:0]        rsum;
  logic [29:0]        rmag;
  logic signed [32:0] rsgn, rtot;
  assign rsum = 46'(y_p) + 46'h8000;
  assign rmag = rsum[45:16];
  assign rsgn = y_neg ? -$signed({3'b000, rmag}) : $signed({3'b000, rmag});
  assign rtot = rsgn + $signed({{17{mean_offset[CFG_DATA_W-1]}}, mean_offset});

  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= 1'b0;
      x_valid   <= 1'b0;
      y_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        sel <= ~sel;
      end
      if (b_adv) begin
        x_valid   <= issue;
        y_valid   <= x_valid;
        out_valid <= y_valid;
      end
    end
    if (b_adv) begin
      x_prod <= 56'(mag_sel) * 56'(head_item.g);
      x_h    <= head_item.h;
      x_neg  <= sel ? head_item.pair.neg2 : head_item.pair.neg1;
      x_last <= sel;
      y_p    <= 45'(zmag) * 45'(std_scale);
      y_neg  <= x_neg;
      y_last <= x_last;
      if (rtot > SAMPLE_MAX) begin
        out_sample <= SAMPLE_MAX[SAMPLE_W-1:0];
      end else if (rtot < SAMPLE_MIN) begin
        out_sample <= SAMPLE_MIN[SAMPLE_W-1:0];
      end else begin
        out_sample <= rtot[SAMPLE_W-1:0];
      end
      out_last <= y_last;
    end
  end

endmodule

// ----- rtl/pgg_checker.sv -----
`include "polar_gaussian_generator_unit_macros.svh"

module pgg_checker import pgg_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [SAMPLE_W-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // samples leave in pairs: first without tlast, second with it
  logic expect_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_last <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      expect_last <= ~expect_last;
    end
  end

  `PGG_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output valid dropped while stalled")
  `PGG_ASSERT(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "output payload changed while stalled")
  `PGG_ASSERT(a_pair_order, clk, rst, m_axis_tvalid && m_axis_tready |-> m_axis_tlast == expect_last, "samples out of pair order")
  `PGG_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind polar_gaussian_generator_unit pgg_checker u_pgg_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
